[hw/rtl/dsel_pkg.sv]
// Shared types and constants for the debounced switch event latch.
package dsel_pkg;

   localparam int CHANNELS_DEF     = 8;
   localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

   // action codes
   localparam logic [2:0] ACT_EDGE          = 3'd0;
   localparam logic [2:0] ACT_CLEAR_PRESSED = 3'd1;
   localparam logic [2:0] ACT_CLEAR_RELEASE = 3'd2;
   localparam logic [2:0] ACT_READ          = 3'd3;
   localparam logic [2:0] ACT_REBASE        = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [2:0]  channel;
      logic        pin_level;
      logic [31:0] now_tick;
      logic [15:0] encoder_count;
   } req_type;

   typedef struct packed {
      logic               pressed_flag;
      logic               released_flag;
      logic               held_flag;
      logic signed [15:0] encoder_delta;
   } rsp_type;

   // one channel entry of the state memory
   typedef struct packed {
      logic        held;
      logic        released;
      logic        pressed;
      logic [31:0] tick;
   } entry_type;

endpackage

[hw/rtl/debounced_switch_event_latch.sv]
// Top level of the debounced switch event latch.
//
// Usage:
//   req_*  : one transaction per action (edge event, clear pressed, clear
//            released, read, rebase encoder) on a valid/ready channel.
//   rsp_*  : exactly one response per request, in order: the addressed
//            channel's pressed/released/held flags after the update and the
//            signed encoder delta in detents since the last rebase.
//   csr_*  : write-only lockout length in ticks; write only while idle.
// Pipeline: an accepted request is registered into the update stage while the
//   state memory is read; the update and write-back land with the response
//   register when that stage retires, and the response is offered from there.
// Throughput: one transaction per cycle unless rsp_ready stalls. A back-to-back
//   request to the same channel takes the just-written entry from a forwarding
//   register, since the memory read and the write-back share an edge.
// Reset: flags and accept ticks read as zero through per-entry valid bits,
//   encoder reference cleared, lockout back to 20 ticks. No clearing pass.
// Stall: while rsp_ready is low with a response waiting, the update stage
//   holds and req_ready drops once that stage is occupied.
module debounced_switch_event_latch #(
   parameter int CHANNELS = dsel_pkg::CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dsel_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dsel_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);
   import dsel_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // lockout register
   logic [15:0] debounce_ff, debounce_in;

   // update stage
   req_type     s2_item_ff, s2_item_in;
   logic        s2_valid_ff, s2_valid_in;
   logic        fwd_hit_ff, fwd_hit_in;
   entry_type   fwd_data_ff, fwd_data_in;
   logic [13:0] enc_ref_ff, enc_ref_in;

   // response register
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic             fire2;
   logic             s2_chan_ok;
   logic [IDX_W-1:0] req_idx, s2_idx;
   entry_type        mem_q, cur_entry, nxt_entry;
   logic [13:0]      s2_detents;

   assign req_idx    = IDX_W'(req_data.channel);
   assign s2_idx     = IDX_W'(s2_item_ff.channel);
   assign s2_chan_ok = {29'd0, s2_item_ff.channel} < 32'(CHANNELS);
   assign s2_detents = s2_item_ff.encoder_count[15:2];

   // update stage retires when the response register is free or draining
   assign fire2     = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s2_valid_ff || fire2;
   assign accept    = req_valid && req_ready;

   assign cur_entry = fwd_hit_ff ? fwd_data_ff : mem_q;

   dsel_mem #(
      .CHANNELS (CHANNELS),
      .IDX_W    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_idx  (req_idx),
      .rd_data (mem_q),
      .wr_en   (fire2 && s2_chan_ok),
      .wr_idx  (s2_idx),
      .wr_data (nxt_entry)
   );

   dsel_update u_update (
      .item     (s2_item_ff),
      .cur      (cur_entry),
      .debounce (debounce_ff),
      .nxt      (nxt_entry)
   );

   always_comb begin
      debounce_in  = csr_wr_en ? csr_wr_data : debounce_ff;

      s2_item_in   = s2_item_ff;
      s2_valid_in  = s2_valid_ff;
      fwd_hit_in   = fwd_hit_ff;
      fwd_data_in  = fwd_data_ff;
      if (accept) begin
         s2_item_in  = req_data;
         s2_valid_in = 1'b1;
         // memory read this edge misses the write-back landing on the same edge
         fwd_hit_in  = fire2 && s2_chan_ok && (s2_idx == req_idx);
         fwd_data_in = nxt_entry;
      end else if (fire2) begin
         s2_valid_in = 1'b0;
      end

      enc_ref_in = enc_ref_ff;
      if (fire2 && (s2_item_ff.action == ACT_REBASE)) begin
         enc_ref_in = s2_detents;
      end

      rsp_in = rsp_ff;
      if (fire2) begin
         rsp_in.pressed_flag  = s2_chan_ok & nxt_entry.pressed;
         rsp_in.released_flag = s2_chan_ok & nxt_entry.released;
         rsp_in.held_flag     = s2_chan_ok & nxt_entry.held;
         rsp_in.encoder_delta = signed'({2'b00, s2_detents} - {2'b00, enc_ref_in});
      end

      rsp_valid_in = rsp_valid_ff;
      if (fire2) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RESET;
         s2_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         enc_ref_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         debounce_ff  <= debounce_in;
         s2_valid_ff  <= s2_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
         enc_ref_ff   <= enc_ref_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s2_item_ff  <= s2_item_in;
      fwd_data_ff <= fwd_data_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/dsel_mem.sv]
// Channel state memory: registered synchronous read, per-entry valid bits.
module dsel_mem #(
   parameter int CHANNELS = dsel_pkg::CHANNELS_DEF,
   parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_idx,
   output dsel_pkg::entry_type  rd_data,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_idx,
   input  dsel_pkg::entry_type  wr_data
);
   import dsel_pkg::*;

   entry_type            mem [CHANNELS];
   entry_type            q_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [CHANNELS-1:0]  valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         q_ff      <= mem[rd_idx];
         rd_idx_ff <= rd_idx;
      end
   end

   // an entry never written reads as the reset value, zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   assign rd_data = valid_ff[rd_idx_ff] ? q_ff : '0;

endmodule

[hw/rtl/dsel_update.sv]
// Per-transaction entry update: lockout test, flag set and clear.
module dsel_update (
   input  dsel_pkg::req_type    item,
   input  dsel_pkg::entry_type  cur,
   input  logic [15:0]          debounce,
   output dsel_pkg::entry_type  nxt
);
   import dsel_pkg::*;

   logic [31:0] limit;
   logic        edge_ok;

   assign limit   = cur.tick + {16'd0, debounce};  // wraps at 32 bits
   assign edge_ok = limit < item.now_tick;

   always_comb begin
      nxt = cur;
      case (item.action)
         ACT_EDGE: begin
            if (edge_ok) begin
               nxt.tick = item.now_tick;
               if (!item.pin_level) begin
                  nxt.held    = 1'b1;
                  nxt.pressed = 1'b1;
               end else begin
                  nxt.held     = 1'b0;
                  nxt.released = 1'b1;
               end
            end
         end
         ACT_CLEAR_PRESSED: nxt.pressed  = 1'b0;
         ACT_CLEAR_RELEASE: nxt.released = 1'b0;
         default: nxt = cur;  // read, rebase, unused codes
      endcase
   end

endmodule
